// ===== sv/aes_pkg.sv =====
// AES-128 package: S-box tables, GF(2^8) helpers, register indexes.
// Used by the key schedule, round unit and engine of the aes_block_cipher block.
`default_nettype none
package aes_pkg;

  localparam int NumRounds  = 10;
  localparam int StoreDepth = 2 * (NumRounds + 1);
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int RoundW     = $clog2(NumRounds + 1);
  localparam int IdxW       = 1;

  localparam logic [IdxW-1:0] RegKeyHi = 1'b0;
  localparam logic [IdxW-1:0] RegKeyLo = 1'b1;

  localparam logic ActEncrypt = 1'b0;
  localparam logic ActDecrypt = 1'b1;

  localparam logic [7:0] FwdSub [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] InvSub [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    gf_dbl = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // S-box applied to each of the four bytes of a 32-bit word
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {FwdSub[w[31:24]], FwdSub[w[23:16]], FwdSub[w[15:8]], FwdSub[w[7:0]]};
  endfunction

endpackage : aes_pkg
`default_nettype wire

// ===== sv/aes_stream_if.sv =====
// Valid/ready channel interface with a generic payload type.
// Depends on nothing; payload type set by the instantiating scope.
`default_nettype none
interface aes_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : aes_stream_if
`default_nettype wire

// ===== sv/aes_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Standalone; used for the round key store.
`default_nettype none
module aes_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule : aes_ram
`default_nettype wire

// ===== sv/aes_key_expand.sv =====
// Key schedule sequencer: writes each round key into the key store as two words, high then low.
// Depends on aes_pkg.
`default_nettype none
module aes_key_sched (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [127:0]              key_i,
  output logic                           busy_o,
  output logic                           we_o,
  output logic [aes_pkg::AddrW-1:0]      waddr_o,
  output logic [63:0]                    wdata_o
);
  import aes_pkg::*;

  logic [127:0]     rk_q, rk_d;
  logic [7:0]       rc_q, rc_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             busy_q, busy_d;
  logic [31:0]      t, w0, w1, w2, w3;

  always_comb begin
    t  = sub_word({rk_q[23:0], rk_q[31:24]}) ^ {rc_q, 24'h0};
    w0 = rk_q[127:96] ^ t;
    w1 = rk_q[95:64] ^ w0;
    w2 = rk_q[63:32] ^ w1;
    w3 = rk_q[31:0] ^ w2;
    rk_d   = rk_q;
    rc_d   = rc_q;
    addr_d = addr_q;
    busy_d = busy_q;
    if (start_i) begin
      rk_d   = key_i;
      rc_d   = 8'h01;
      addr_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      addr_d = addr_q + AddrW'(1);
      if (addr_q[0]) begin
        rk_d = {w0, w1, w2, w3};
        rc_d = gf_dbl(rc_q);
      end
      if (addr_q == AddrW'(StoreDepth - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      addr_q <= '0;
      rc_q   <= 8'h01;
      rk_q   <= '0;
    end else begin
      busy_q <= busy_d;
      addr_q <= addr_d;
      rc_q   <= rc_d;
      rk_q   <= rk_d;
    end
  end

  assign busy_o  = busy_q;
  assign we_o    = busy_q;
  assign waddr_o = addr_q;
  assign wdata_o = addr_q[0] ? rk_q[63:0] : rk_q[127:64];
endmodule : aes_key_sched
`default_nettype wire

// ===== sv/aes_round.sv =====
// Shared AES round datapath, forward and inverse, combinational.
// Depends on aes_pkg.
`default_nettype none
module aes_round (
  input  wire logic         inv_i,
  input  wire logic         mix_i,
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] key_i,
  output logic      [127:0] state_o
);
  import aes_pkg::*;

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] a [16];
  logic [7:0] m [16];
  logic [7:0] c0, c1, c2, c3, x2_0, x2_1, x2_2, x2_3, x4_0, x4_1, x4_2, x4_3;
  logic [7:0] x8_0, x8_1, x8_2, x8_3;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv_i) begin
          t[((c + r) & 3) * 4 + r] = InvSub[s[c*4+r]];
        end else begin
          t[c*4+r] = FwdSub[s[((c + r) & 3) * 4 + r]];
        end
      end
    end
    // inverse: add key before mix; forward: after
    for (int i = 0; i < 16; i++) begin
      a[i] = inv_i ? (t[i] ^ key_i[127-8*i -: 8]) : t[i];
    end
    for (int c = 0; c < 4; c++) begin
      c0 = a[c*4]; c1 = a[c*4+1]; c2 = a[c*4+2]; c3 = a[c*4+3];
      x2_0 = gf_dbl(c0); x2_1 = gf_dbl(c1); x2_2 = gf_dbl(c2); x2_3 = gf_dbl(c3);
      x4_0 = gf_dbl(x2_0); x4_1 = gf_dbl(x2_1); x4_2 = gf_dbl(x2_2); x4_3 = gf_dbl(x2_3);
      x8_0 = gf_dbl(x4_0); x8_1 = gf_dbl(x4_1); x8_2 = gf_dbl(x4_2); x8_3 = gf_dbl(x4_3);
      if (inv_i) begin
        // 0e=8^4^2, 0b=8^2^1, 0d=8^4^1, 09=8^1
        m[c*4]   = (x8_0^x4_0^x2_0) ^ (x8_1^x2_1^c1) ^ (x8_2^x4_2^c2) ^ (x8_3^c3);
        m[c*4+1] = (x8_0^c0) ^ (x8_1^x4_1^x2_1) ^ (x8_2^x2_2^c2) ^ (x8_3^x4_3^c3);
        m[c*4+2] = (x8_0^x4_0^c0) ^ (x8_1^c1) ^ (x8_2^x4_2^x2_2) ^ (x8_3^x2_3^c3);
        m[c*4+3] = (x8_0^x2_0^c0) ^ (x8_1^x4_1^c1) ^ (x8_2^c2) ^ (x8_3^x4_3^x2_3);
      end else begin
        m[c*4]   = x2_0 ^ (x2_1^c1) ^ c2 ^ c3;
        m[c*4+1] = c0 ^ x2_1 ^ (x2_2^c2) ^ c3;
        m[c*4+2] = c0 ^ c1 ^ x2_2 ^ (x2_3^c3);
        m[c*4+3] = (x2_0^c0) ^ c1 ^ c2 ^ x2_3;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (inv_i) begin
        state_o[127-8*i -: 8] = mix_i ? m[i] : a[i];
      end else begin
        state_o[127-8*i -: 8] = (mix_i ? m[i] : a[i]) ^ key_i[127-8*i -: 8];
      end
    end
  end
endmodule : aes_round
`default_nettype wire

// ===== sv/aes_block_cipher.sv =====
// AES-128 encrypt/decrypt engine, iterative: one round at a time in a shared
// round unit. The 128-bit round key comes from a 64-bit-wide key store with
// registered reads, so the initial key add and each of the ten rounds take
// three steps (read high word, read low word, compute). A block is taken
// only in idle, so a new one waits until the last is through; the next is
// taken at the earliest in the cycle after the result is registered. A key
// register write blocks input in its own cycle, during the key schedule start
// pulse and for the whole key expansion. A block is accepted while a previous
// result waits in the output register; it then holds in its last round until
// that result is taken. Blocks sent before any key write are undefined.
`default_nettype none
module aes_block_cipher (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [aes_pkg::IdxW-1:0] cfg_idx_i,
  input  wire logic [63:0]            cfg_wdata_i,
  aes_stream_if.sink                  in_i,
  aes_stream_if.source                out_o
);
  import aes_pkg::*;

  typedef enum logic [1:0] {StIdle, StRdHi, StRdLo, StRun} state_e;

  state_e            state_q;
  logic [63:0]       key_hi_q, key_lo_q;
  logic              kx_start_q, kx_busy, kx_we;
  logic [AddrW-1:0]  kx_addr, rd_addr;
  logic [63:0]       kx_data, rd_data;
  logic [127:0]      st_q, rnd_out, rk;
  logic [63:0]       khi_q;
  logic              inv_q, first_q;
  logic [RoundW-1:0] rnd_q;
  logic              out_valid_q;
  logic [127:0]      out_q;
  logic              in_xfer, out_xfer, mix, res_load;
  logic [RoundW-1:0] key_num;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign in_i.ready = (state_q == StIdle) && !kx_busy && !kx_start_q && !cfg_we_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q   <= '0;
      key_lo_q   <= '0;
      kx_start_q <= 1'b0;
    end else begin
      kx_start_q <= cfg_we_i;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegKeyHi: key_hi_q <= cfg_wdata_i;
          RegKeyLo: key_lo_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  aes_key_sched u_kx (
    .clk_i, .rst_ni,
    .start_i (kx_start_q),
    .key_i   ({key_hi_q, key_lo_q}),
    .busy_o  (kx_busy),
    .we_o    (kx_we),
    .waddr_o (kx_addr),
    .wdata_o (kx_data)
  );

  // round key number used by the pending step; low word held while in StRun
  assign key_num = inv_q ? RoundW'(NumRounds) - rnd_q : rnd_q;
  assign rd_addr = {key_num[AddrW-2:0], (state_q == StRdLo) || (state_q == StRun)};

  aes_ram #(.Width(64), .Depth(StoreDepth)) u_store (
    .clk_i,
    .we_i    (kx_we),
    .waddr_i (kx_addr),
    .wdata_i (kx_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign rk  = {khi_q, rd_data};
  assign mix = (rnd_q != RoundW'(NumRounds));

  assign res_load = (state_q == StRun) && !first_q && (rnd_q == RoundW'(NumRounds)) &&
                    (!out_valid_q || out_xfer);

  aes_round u_round (
    .inv_i   (inv_q),
    .mix_i   (mix),
    .state_i (st_q),
    .key_i   (rk),
    .state_o (rnd_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      inv_q       <= 1'b0;
      first_q     <= 1'b0;
      rnd_q       <= '0;
      st_q        <= '0;
      khi_q       <= '0;
      out_q       <= '0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_xfer) begin
            st_q    <= {in_i.data.block_hi, in_i.data.block_lo};
            inv_q   <= (in_i.data.action == ActDecrypt);
            first_q <= 1'b1;
            rnd_q   <= '0;
            state_q <= StRdHi;
          end
        end
        StRdHi: begin
          state_q <= StRdLo;
        end
        StRdLo: begin
          khi_q   <= rd_data;
          state_q <= StRun;
        end
        StRun: begin
          if (first_q) begin
            st_q    <= st_q ^ rk;
            first_q <= 1'b0;
            rnd_q   <= RoundW'(1);
            state_q <= StRdHi;
          end else if (res_load) begin
            out_q   <= rnd_out;
            state_q <= StIdle;
          end else if (rnd_q != RoundW'(NumRounds)) begin
            st_q    <= rnd_out;
            rnd_q   <= rnd_q + RoundW'(1);
            state_q <= StRdHi;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.data.out_hi = out_q[127:64];
  assign out_o.data.out_lo = out_q[63:0];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> !kx_busy)
    else $error("block accepted during key expansion");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == StRdHi)
    else $error("sequencer did not start after transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> $stable(out_q))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_i.ready)
    else $error("ready while busy");
endmodule : aes_block_cipher
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for aes_block_cipher: directed known-answer table, then random
// blocks under random keys, checked against an in-bench AES-128 predictor.
// Depends on aes_pkg (tables, indexes) and aes_stream_if.
module testbench;
  import aes_pkg::*;

  typedef struct packed {
    logic        action;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } blk_t;

  typedef struct packed {
    logic [63:0] out_hi;
    logic [63:0] out_lo;
  } res_t;

  typedef struct {
    logic         ld_key;
    logic [127:0] key;
    logic         act;
    logic [127:0] blk;
    logic         has_exp;
    logic [127:0] expv;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IdxW-1:0] cfg_idx_i = RegKeyHi;
  logic [63:0] cfg_wdata_i = '0;

  aes_stream_if #(.payload_t(blk_t)) in_if ();
  aes_stream_if #(.payload_t(res_t)) out_if ();

  aes_block_cipher i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  initial begin
    #20ms;
    $display("timeout waiting for results");
    $display("FAIL aes_block_cipher");
    $finish;
  end

  // predictor state
  logic [63:0]  key_hi_q = '0, key_lo_q = '0;
  logic [127:0] rkeys [11];
  res_t         exp_q [$];
  int           errors = 0, n_res = 0, n_enc = 0, n_dec = 0, n_keys = 0;
  logic         cur_has = 1'b0;
  logic [127:0] cur_exp = '0;
  logic         send_idle = 1'b1, recv_idle = 1'b1, long_hold = 1'b0;

  function automatic logic [7:0] xtime(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = xtime(a);
    end
    return acc;
  endfunction

  function automatic logic [7:0] byte_at(logic [127:0] s, int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic void expand_keys();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    {w[0], w[1], w[2], w[3]} = {key_hi_q, key_lo_q};
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {FwdSub[t[23:16]] ^ rc, FwdSub[t[15:8]], FwdSub[t[7:0]], FwdSub[t[31:24]]};
        rc = xtime(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) rkeys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic logic [127:0] sub_shift(logic [127:0] s, logic inv);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (inv) t[127-8*(((c+r)&3)*4+r) -: 8] = InvSub[byte_at(s, c*4+r)];
        else t[127-8*(c*4+r) -: 8] = FwdSub[byte_at(s, ((c+r)&3)*4+r)];
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] s, logic inv);
    logic [7:0]   m [4];
    logic [7:0]   v;
    logic [127:0] t;
    if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        v = '0;
        for (int j = 0; j < 4; j++) v ^= gmul(byte_at(s, c*4+j), m[(j-r+4)&3]);
        t[127-8*(c*4+r) -: 8] = v;
      end
    return t;
  endfunction

  function automatic logic [127:0] aes_predict(logic act, logic [127:0] blk);
    logic [127:0] s;
    s = blk;
    if (act == ActEncrypt) begin
      s ^= rkeys[0];
      for (int r = 1; r <= NumRounds; r++) begin
        s = sub_shift(s, 1'b0);
        if (r < NumRounds) s = mix_cols(s, 1'b0);
        s ^= rkeys[r];
      end
    end else begin
      s ^= rkeys[NumRounds];
      for (int r = NumRounds - 1; r >= 0; r--) begin
        s = sub_shift(s, 1'b1);
        s ^= rkeys[r];
        if (r > 0) s = mix_cols(s, 1'b1);
      end
    end
    return s;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // input transfer: record expectation
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      if (cur_has) exp_q.push_back(cur_exp);
      else exp_q.push_back(aes_predict(in_if.data.action,
                                       {in_if.data.block_hi, in_if.data.block_lo}));
      if (in_if.data.action == ActEncrypt) n_enc++;
      else n_dec++;
    end
  end

  // output transfer: compare
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_res++;
      if (exp_q.size() == 0) begin
        report("unexpected out_hi", out_if.data.out_hi, '0);
      end else begin
        want = exp_q.pop_front();
        if (out_if.data.out_hi !== want.out_hi) report("out_hi", out_if.data.out_hi, want.out_hi);
        if (out_if.data.out_lo !== want.out_lo) report("out_lo", out_if.data.out_lo, want.out_lo);
      end
    end
  end

  // receiver
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_if.ready <= 1'b0;
        for (int i = 0; i < 300; i++) @(negedge clk_i);
        long_hold = 1'b0;
      end else begin
        gap = recv_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  task automatic send_block(logic act, logic [127:0] blk, logic has, logic [127:0] expv);
    int gap;
    gap = send_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_has <= has;
    cur_exp <= expv;
    in_if.data <= '{action: act, block_hi: blk[127:64], block_lo: blk[63:0]};
    in_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [IdxW-1:0] idx, logic [63:0] val);
    in_if.valid <= 1'b0;
    while (exp_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegKeyHi) key_hi_q = val;
    else key_lo_q = val;
    expand_keys();
    n_keys++;
  endtask

  function automatic row_t mk(logic ld, logic [127:0] k, logic a, logic [127:0] b,
                              logic h, logic [127:0] e);
    return '{ld_key: ld, key: k, act: a, blk: b, has_exp: h, expv: e};
  endfunction

  localparam logic [127:0] FipsKey = 128'h000102030405060708090a0b0c0d0e0f;
  localparam logic [127:0] FipsPt  = 128'h00112233445566778899aabbccddeeff;
  localparam logic [127:0] FipsCt  = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
  localparam logic [127:0] ZeroCt  = 128'h66e94bd4ef8a2c3b884cfa59ca342b2e;
  localparam logic [127:0] Ones    = '1;

  initial begin
    row_t         dir [$];
    logic [127:0] k, b;
    dir.push_back(mk(1'b1, FipsKey, ActEncrypt, FipsPt, 1'b1, FipsCt));
    dir.push_back(mk(1'b0, '0, ActDecrypt, FipsCt, 1'b1, FipsPt));
    dir.push_back(mk(1'b0, '0, ActEncrypt, '0, 1'b0, '0));
    dir.push_back(mk(1'b0, '0, ActEncrypt, Ones, 1'b0, '0));
    dir.push_back(mk(1'b0, '0, ActDecrypt, '0, 1'b0, '0));
    dir.push_back(mk(1'b0, '0, ActDecrypt, Ones, 1'b0, '0));
    dir.push_back(mk(1'b0, '0, ActEncrypt, {1'b1, 127'b0}, 1'b0, '0));
    dir.push_back(mk(1'b0, '0, ActDecrypt, 128'h1, 1'b0, '0));
    dir.push_back(mk(1'b0, '0, ActEncrypt, {16{8'haa}}, 1'b0, '0));
    dir.push_back(mk(1'b0, '0, ActDecrypt, {16{8'h55}}, 1'b0, '0));
    dir.push_back(mk(1'b1, '0, ActEncrypt, '0, 1'b1, ZeroCt));
    dir.push_back(mk(1'b0, '0, ActDecrypt, ZeroCt, 1'b1, '0));
    dir.push_back(mk(1'b0, '0, ActEncrypt, Ones, 1'b0, '0));
    dir.push_back(mk(1'b1, Ones, ActEncrypt, '0, 1'b0, '0));
    dir.push_back(mk(1'b0, '0, ActDecrypt, Ones, 1'b0, '0));
    dir.push_back(mk(1'b0, '0, ActEncrypt, FipsPt, 1'b0, '0));
    dir.push_back(mk(1'b0, '0, ActDecrypt, FipsPt, 1'b0, '0));

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir[i]) begin
      if (dir[i].ld_key) begin
        write_reg(RegKeyHi, dir[i].key[127:64]);
        write_reg(RegKeyLo, dir[i].key[63:0]);
      end
      send_block(dir[i].act, dir[i].blk, dir[i].has_exp, dir[i].expv);
    end

    for (int ph = 0; ph < 8; ph++) begin
      k = {$urandom, $urandom, $urandom, $urandom};
      if (ph == 3) k = '0;
      if (ph == 5) k = Ones;
      if (ph == 6) write_reg(RegKeyLo, k[63:0]);
      else begin
        write_reg(RegKeyHi, k[127:64]);
        write_reg(RegKeyLo, k[63:0]);
      end
      send_idle = (ph % 3) != 2;
      recv_idle = (ph % 4) != 3;
      if (ph == 1) long_hold = 1'b1;
      for (int n = 0; n < 125; n++) begin
        b = {$urandom, $urandom, $urandom, $urandom};
        send_block(1'($urandom_range(0, 1)), b, 1'b0, '0);
      end
    end
    in_if.valid <= 1'b0;

    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d encrypt and %0d decrypt blocks, %0d results, %0d key writes",
             n_enc, n_dec, n_res, n_keys);
    if (errors == 0) begin
      $display("PASS aes_block_cipher");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL aes_block_cipher");
    end
    $finish;
  end

endmodule
